@@ design/bsps_pkg.sv @@
`default_nettype none

package bsps_pkg;

  // Output format constants
  localparam int KW = 6;                               // sample index width
  localparam logic signed [15:0] Q14_ONE = 16'sd16384;  // 1.0 in Q2.14

  // Internal widths
  localparam int PTW  = 33;  // control point (P1/P2 may need 33 bits)
  localparam int DDW  = 35;  // control point differences
  localparam int NUMW = 53;  // position numerator
  localparam int TW   = 48;  // scaled tangent
  localparam int MAGW = 46;  // tangent magnitude before reduction
  localparam int UW   = 30;  // reduced tangent magnitude

  // Sideband into the position divider
  typedef struct packed {
    logic [2:0]           negp;
    logic [2:0][MAGW-1:0] um;
    logic [2:0]           negd;
    logic [KW-1:0]        k;
    logic                 last;
  } pd_side_t;

  // Sideband into the length square roots
  typedef struct packed {
    logic [2:0][31:0]   pos;
    logic [2:0][UW-1:0] u;
    logic [2:0]         negd;
    logic [KW-1:0]      k;
    logic               last;
  } sa_side_t;

  // Sideband through the half-angle divide and root
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [UW-1:0]    uy;
    logic [UW-1:0]    uz;
    logic [30:0]      r;
    logic             negy;
    logic             negz;
    logic             spec;
    logic             ident;
    logic [KW-1:0]    k;
    logic             last;
  } db_side_t;

  // Sideband through the axis divide
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [14:0]      qw;
    logic             negy;
    logic             negz;
    logic             spec;
    logic             ident;
    logic [KW-1:0]    k;
    logic             last;
  } dd_side_t;

endpackage

`default_nettype wire

@@ design/bsps_div.sv @@
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage, shared divisor.
module bsps_div #(
  parameter int LANES = 1,
  parameter int NW    = 8,
  parameter int DW    = 4,
  parameter int QW    = 4,
  parameter int SW    = 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic [LANES-1:0][NW-1:0]    num,
  input  wire logic [DW-1:0]               den,
  input  wire logic [SW-1:0]               side_in,
  output logic                             out_valid,
  output logic [LANES-1:0][QW-1:0]         quo,
  output logic [SW-1:0]                    side_out
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic                       vld [0:QW];
  logic [LANES-1:0][NW-1:0]   rem [0:QW];
  logic [LANES-1:0][QW-1:0]   qp  [0:QW];
  logic [DW-1:0]              dv  [0:QW];
  logic [SW-1:0]              sd  [0:QW];

  assign vld[0] = in_valid;
  assign rem[0] = num;
  assign qp[0]  = '0;
  assign dv[0]  = den;
  assign sd[0]  = side_in;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int SH = QW - 1 - j;
    logic [CW-1:0]              dsh;
    logic [LANES-1:0][NW-1:0]   rem_next;
    logic [LANES-1:0][QW-1:0]   qp_next;

    assign dsh = CW'(dv[j]) << SH;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        if (CW'(rem[j][l]) >= dsh) begin
          rem_next[l] = NW'(CW'(rem[j][l]) - dsh);
          qp_next[l]  = qp[j][l] | (QW'(1) << SH);
        end else begin
          rem_next[l] = rem[j][l];
          qp_next[l]  = qp[j][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
      rem[j+1] <= rem_next;
      qp[j+1]  <= qp_next;
      dv[j+1]  <= dv[j];
      sd[j+1]  <= sd[j];
    end
  end

  assign out_valid = vld[QW];
  assign quo       = qp[QW];
  assign side_out  = sd[QW];

endmodule

`default_nettype wire

@@ design/bsps_sqrt.sv @@
`default_nettype none

// Pipelined digit-by-digit integer square root, one root bit per stage.
// Gives floor root and remainder x - root^2.
module bsps_sqrt #(
  parameter int LANES = 1,
  parameter int XW    = 8,
  parameter int SW    = 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [LANES-1:0][XW-1:0]      x,
  input  wire logic [SW-1:0]                 side_in,
  output logic                               out_valid,
  output logic [LANES-1:0][XW/2-1:0]         root,
  output logic [LANES-1:0][XW/2+1:0]         rem,
  output logic [SW-1:0]                      side_out
);

  localparam int RW  = XW / 2;
  localparam int RMW = RW + 2;

  logic                       vld [0:RW];
  logic [LANES-1:0][XW-1:0]   xs  [0:RW];
  logic [LANES-1:0][RMW-1:0]  rm  [0:RW];
  logic [LANES-1:0][RW-1:0]   rt  [0:RW];
  logic [SW-1:0]              sd  [0:RW];

  assign vld[0] = in_valid;
  assign xs[0]  = x;
  assign rm[0]  = '0;
  assign rt[0]  = '0;
  assign sd[0]  = side_in;

  for (genvar j = 0; j < RW; j++) begin : g_stage
    logic [LANES-1:0][RMW-1:0] rm_next;
    logic [LANES-1:0][RW-1:0]  rt_next;
    logic [LANES-1:0][RMW-1:0] rsh;
    logic [LANES-1:0][RMW-1:0] trial;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        rsh[l]   = {rm[j][l][RMW-3:0], xs[j][l][XW-1:XW-2]};
        trial[l] = (RMW'(rt[j][l]) << 2) | RMW'(1);
        if (rsh[l] >= trial[l]) begin
          rm_next[l] = rsh[l] - trial[l];
          rt_next[l] = {rt[j][l][RW-2:0], 1'b1};
        end else begin
          rm_next[l] = rsh[l];
          rt_next[l] = {rt[j][l][RW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
      for (int l = 0; l < LANES; l++) begin
        xs[j+1][l] <= {xs[j][l][XW-3:0], 2'b00};
      end
      rm[j+1] <= rm_next;
      rt[j+1] <= rt_next;
      sd[j+1] <= sd[j];
    end
  end

  assign out_valid = vld[RW];
  assign root      = rt[RW];
  assign rem       = rm[RW];
  assign side_out  = sd[RW];

endmodule

`default_nettype wire

@@ design/bezier_segment_pose_sampler.sv @@
`default_nettype none

// Cubic Bezier segment pose sampler. Pulse start with a segment (start point,
// outgoing handle, incoming handle, end point, all Q16.16) while busy is low;
// the block then issues SAMPLES samples t = k/SAMPLES, one per clock, into a
// fully pipelined evaluator, so a new segment is taken as soon as the last
// sample is issued (busy drops during the last issue cycle, so segments run
// back to back). Each pose comes out on the result ports for exactly one cycle
// with valid high, in order of k, after a chain of pipelined units (position
// reciprocal multiply, tangent length roots, half-angle divide and root, axis
// divide). Results cannot be held off: the receiver must take every valid
// cycle. Position is rounded to nearest and saturated; the quaternion (qx is
// always zero) turns +x onto the tangent, with identity for a tangent along
// +x and qz = 1 for a tangent along -x or a zero tangent.
module bezier_segment_pose_sampler #(
  parameter int SAMPLES = 20
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] start_x,
  input  wire logic signed [31:0] start_y,
  input  wire logic signed [31:0] start_z,
  input  wire logic signed [31:0] out_handle_x,
  input  wire logic signed [31:0] out_handle_y,
  input  wire logic signed [31:0] out_handle_z,
  input  wire logic signed [31:0] in_handle_x,
  input  wire logic signed [31:0] in_handle_y,
  input  wire logic signed [31:0] in_handle_z,
  input  wire logic signed [31:0] end_x,
  input  wire logic signed [31:0] end_y,
  input  wire logic signed [31:0] end_z,
  output logic                    valid,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic signed [31:0]      pos_z,
  output logic signed [15:0]      quat_w,
  output logic signed [15:0]      quat_y,
  output logic signed [15:0]      quat_z,
  output logic [5:0]              sample_index,
  output logic                    last_sample
);

  localparam int KW   = bsps_pkg::KW;
  localparam int PTW  = bsps_pkg::PTW;
  localparam int DDW  = bsps_pkg::DDW;
  localparam int NUMW = bsps_pkg::NUMW;
  localparam int TW   = bsps_pkg::TW;
  localparam int MAGW = bsps_pkg::MAGW;
  localparam int UW   = bsps_pkg::UW;

  localparam int N3   = SAMPLES * SAMPLES * SAMPLES;
  localparam int HALF = N3 / 2;
  localparam logic [KW-1:0] LASTK = KW'(SAMPLES - 1);

  // Reciprocal of n^3, rounded up, exact floor for numerators below 2^52
  localparam int PD_SH = 52 + $clog2(N3);
  localparam logic [127:0] PD_M =
    ((128'd1 << PD_SH) + 128'(N3) - 128'd1) / 128'(N3);
  localparam logic [25:0] PD_M0 = PD_M[25:0];
  localparam logic [26:0] PD_M1 = PD_M[52:26];

  // ---------------------------------------------------------------------
  // Sequencer: holds the segment and issues one k per cycle
  // ---------------------------------------------------------------------
  logic              active;
  logic [KW-1:0]     k;
  logic signed [PTW-1:0] sp [4][3];   // P0..P3
  logic signed [DDW-1:0] sd [3][3];   // P1-P0, P2-P1, P3-P2
  logic signed [31:0] in_s [3];
  logic signed [31:0] in_o [3];
  logic signed [31:0] in_i [3];
  logic signed [31:0] in_e [3];
  logic signed [PTW-1:0] p1c [3];
  logic signed [PTW-1:0] p2c [3];
  logic take;

  assign busy = active && (k != LASTK);
  assign take = start && !busy;

  always_comb begin
    in_s[0] = start_x;      in_s[1] = start_y;      in_s[2] = start_z;
    in_o[0] = out_handle_x; in_o[1] = out_handle_y; in_o[2] = out_handle_z;
    in_i[0] = in_handle_x;  in_i[1] = in_handle_y;  in_i[2] = in_handle_z;
    in_e[0] = end_x;        in_e[1] = end_y;        in_e[2] = end_z;
    for (int i = 0; i < 3; i++) begin
      p1c[i] = {in_s[i][31], in_s[i]} + {in_o[i][31], in_o[i]};
      p2c[i] = {in_e[i][31], in_e[i]} + {in_i[i][31], in_i[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      k      <= '0;
    end else if (take) begin
      active <= 1'b1;
      k      <= '0;
    end else if (active) begin
      if (k == LASTK) begin
        active <= 1'b0;
      end else begin
        k <= k + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < 3; i++) begin
        sp[0][i] <= {in_s[i][31], in_s[i]};
        sp[1][i] <= p1c[i];
        sp[2][i] <= p2c[i];
        sp[3][i] <= {in_e[i][31], in_e[i]};
        sd[0][i] <= {{3{in_o[i][31]}}, in_o[i]};
        sd[1][i] <= {{2{p2c[i][PTW-1]}}, p2c[i]} - {{2{p1c[i][PTW-1]}}, p1c[i]};
        sd[2][i] <= -{{3{in_i[i][31]}}, in_i[i]};
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: a = n-k, b = k, squares and cross term
  // ---------------------------------------------------------------------
  logic [6:0]  a_cur;
  logic        v1, l1;
  logic [KW-1:0] k1;
  logic [6:0]  a1;
  logic [5:0]  b1;
  logic [12:0] a2_1, ab_1, b2_1;
  logic signed [PTW-1:0] sp1 [4][3];
  logic signed [DDW-1:0] sd1 [3][3];

  assign a_cur = 7'(SAMPLES) - {1'b0, k};

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= active;
    k1   <= k;
    l1   <= (k == LASTK);
    a1   <= a_cur;
    b1   <= k;
    a2_1 <= {6'b0, a_cur} * {6'b0, a_cur};
    ab_1 <= {6'b0, a_cur} * {7'b0, k};
    b2_1 <= {7'b0, k} * {7'b0, k};
    sp1  <= sp;
    sd1  <= sd;
  end

  // ---------------------------------------------------------------------
  // Stage 2: Bernstein weights for position and tangent
  // ---------------------------------------------------------------------
  logic        v2, l2;
  logic [KW-1:0] k2;
  logic [18:0] c2 [4];
  logic [12:0] t2 [3];
  logic signed [PTW-1:0] sp2 [4][3];
  logic signed [DDW-1:0] sd2 [3][3];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    k2    <= k1;
    l2    <= l1;
    c2[0] <= {6'b0, a2_1} * {12'b0, a1};
    c2[1] <= ({6'b0, a2_1} * {13'b0, b1}) * 19'd3;
    c2[2] <= ({6'b0, b2_1} * {12'b0, a1}) * 19'd3;
    c2[3] <= {6'b0, b2_1} * {13'b0, b1};
    t2[0] <= a2_1;
    t2[1] <= {ab_1[11:0], 1'b0};
    t2[2] <= b2_1;
    sp2   <= sp1;
    sd2   <= sd1;
  end

  // ---------------------------------------------------------------------
  // Stage 3: weight times point products
  // ---------------------------------------------------------------------
  logic        v3, l3;
  logic [KW-1:0] k3;
  logic signed [NUMW-1:0] pp3 [3][4];
  logic signed [TW:0]     tp3 [3][3];

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    k3 <= k2;
    l3 <= l2;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) begin
        pp3[i][j] <= $signed({1'b0, c2[j]}) * sp2[j][i];
      end
      for (int j = 0; j < 3; j++) begin
        tp3[i][j] <= $signed({1'b0, t2[j]}) * sd2[j][i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: sums
  // ---------------------------------------------------------------------
  logic        v4, l4;
  logic [KW-1:0] k4;
  logic signed [NUMW-1:0] num4 [3];
  logic signed [TW-1:0]   dt4  [3];

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
    k4 <= k3;
    l4 <= l3;
    for (int i = 0; i < 3; i++) begin
      num4[i] <= pp3[i][0] + pp3[i][1] + pp3[i][2] + pp3[i][3];
      dt4[i]  <= TW'(tp3[i][0] + tp3[i][1] + tp3[i][2]);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: magnitudes; position gets the rounding offset
  // ---------------------------------------------------------------------
  logic        v5;
  logic [2:0][51:0] u5;
  bsps_pkg::pd_side_t pd5;
  logic signed [NUMW-1:0] nabs [3];
  logic signed [TW-1:0]   tabs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nabs[i] = num4[i][NUMW-1] ? -num4[i] : num4[i];
      tabs[i] = dt4[i][TW-1] ? -dt4[i] : dt4[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
    for (int i = 0; i < 3; i++) begin
      u5[i]          <= nabs[i][51:0] + 52'(HALF);
      pd5.negp[i]    <= num4[i][NUMW-1];
      pd5.um[i]      <= tabs[i][MAGW-1:0];
      pd5.negd[i]    <= dt4[i][TW-1];
    end
    pd5.k    <= k4;
    pd5.last <= l4;
  end

  // ---------------------------------------------------------------------
  // Position divide by n^3: multiply by the reciprocal in 26-bit limbs.
  // Partial products, then middle sum, then final sum and shift.
  // ---------------------------------------------------------------------
  logic               pa_v, pb_v, pdv;
  logic [2:0][51:0]   pa00, pa10;
  logic [2:0][52:0]   pa01, pa11;
  logic [2:0][51:0]   pb_lo;
  logic [2:0][53:0]   pb_mid;
  logic [2:0][52:0]   pb_hi;
  logic [105:0]       pfull [3];
  bsps_pkg::pd_side_t pda, pdb, pdo;
  logic [2:0][32:0]   pdq;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pfull[i] = {1'b0, pb_hi[i], 52'b0} + {26'b0, pb_mid[i], 26'b0}
               + {54'b0, pb_lo[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pa_v <= 1'b0;
      pb_v <= 1'b0;
      pdv  <= 1'b0;
    end else begin
      pa_v <= v5;
      pb_v <= pa_v;
      pdv  <= pb_v;
    end
    for (int i = 0; i < 3; i++) begin
      pa00[i]   <= 52'(u5[i][25:0]) * 52'(PD_M0);
      pa01[i]   <= 53'(u5[i][25:0]) * 53'(PD_M1);
      pa10[i]   <= 52'(u5[i][51:26]) * 52'(PD_M0);
      pa11[i]   <= 53'(u5[i][51:26]) * 53'(PD_M1);
      pb_lo[i]  <= pa00[i];
      pb_mid[i] <= 54'(pa01[i]) + 54'(pa10[i]);
      pb_hi[i]  <= pa11[i];
      pdq[i]    <= pfull[i][PD_SH+32 -: 33];
    end
    pda <= pd5;
    pdb <= pda;
    pdo <= pdb;
  end

  // ---------------------------------------------------------------------
  // Stage 6: saturate position; coarse tangent reduction (16, 8, 4)
  // ---------------------------------------------------------------------
  logic        v6;
  logic [2:0][31:0] pos6;
  logic [32:0] m6 [3];
  logic [2:0]  negd6;
  logic [KW-1:0] k6;
  logic        l6;
  logic [MAGW-1:0] rm [3];
  logic [MAGW-1:0] rx;

  always_comb begin
    for (int i = 0; i < 3; i++) rm[i] = pdo.um[i];
    rx = rm[0] | rm[1] | rm[2];
    if (rx[45]) begin
      for (int i = 0; i < 3; i++) rm[i] = rm[i] >> 16;
      rx = rx >> 16;
    end
    if (|rx[45:37]) begin
      for (int i = 0; i < 3; i++) rm[i] = rm[i] >> 8;
      rx = rx >> 8;
    end
    if (|rx[45:33]) begin
      for (int i = 0; i < 3; i++) rm[i] = rm[i] >> 4;
      rx = rx >> 4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else     v6 <= pdv;
    for (int i = 0; i < 3; i++) begin
      if (pdo.negp[i]) begin
        pos6[i] <= (pdq[i] > 33'h080000000) ? 32'h80000000 : 32'(33'd0 - pdq[i]);
      end else begin
        pos6[i] <= (pdq[i] > 33'h07FFFFFFF) ? 32'h7FFFFFFF : pdq[i][31:0];
      end
      m6[i] <= rm[i][32:0];
    end
    negd6 <= pdo.negd;
    k6    <= pdo.k;
    l6    <= pdo.last;
  end

  // ---------------------------------------------------------------------
  // Stage 7: fine reduction (2, 1), all magnitudes below 2^30
  // ---------------------------------------------------------------------
  logic        v7;
  bsps_pkg::sa_side_t s7;
  logic [32:0] fm [3];
  logic [32:0] fx;

  always_comb begin
    for (int i = 0; i < 3; i++) fm[i] = m6[i];
    fx = fm[0] | fm[1] | fm[2];
    if (|fx[32:31]) begin
      for (int i = 0; i < 3; i++) fm[i] = fm[i] >> 2;
      fx = fx >> 2;
    end
    if (fx[30]) begin
      for (int i = 0; i < 3; i++) fm[i] = fm[i] >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else     v7 <= v6;
    for (int i = 0; i < 3; i++) s7.u[i] <= fm[i][UW-1:0];
    s7.pos  <= pos6;
    s7.negd <= negd6;
    s7.k    <= k6;
    s7.last <= l6;
  end

  // ---------------------------------------------------------------------
  // Stage 8: squares; stage 9: radial and full length squared
  // ---------------------------------------------------------------------
  logic        v8, v9;
  logic [59:0] sq8 [3];
  bsps_pkg::sa_side_t s8, s9;
  logic [1:0][61:0] x9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else begin
      v8 <= v7;
      v9 <= v8;
    end
    for (int i = 0; i < 3; i++) sq8[i] <= {30'b0, s7.u[i]} * {30'b0, s7.u[i]};
    s8    <= s7;
    x9[0] <= 62'(sq8[1]) + 62'(sq8[2]);
    x9[1] <= 62'(sq8[0]) + 62'(sq8[1]) + 62'(sq8[2]);
    s9    <= s8;
  end

  // r = floor sqrt(dy^2+dz^2), L = floor sqrt(dx^2+dy^2+dz^2)
  logic               sav;
  logic [1:0][30:0]   sar;
  bsps_pkg::sa_side_t sao;

  bsps_sqrt #(
    .LANES(2), .XW(62), .SW($bits(bsps_pkg::sa_side_t))
  ) u_len_sqrt (
    .clk(clk), .rst(rst), .in_valid(v9), .x(x9), .side_in(s9),
    .out_valid(sav), .root(sar), .rem(), .side_out(sao)
  );

  // ---------------------------------------------------------------------
  // Stage 10: L +/- dx scaled by 2^27, special-case flags
  // ---------------------------------------------------------------------
  logic        v10;
  logic [1:0][58:0] n10;
  logic [30:0] d10;
  bsps_pkg::db_side_t s10;
  logic [31:0] lsum, ldif;

  assign lsum = {1'b0, sar[1]} + {2'b0, sao.u[0]};
  assign ldif = {1'b0, sar[1]} - {2'b0, sao.u[0]};

  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else     v10 <= sav;
    n10[0]    <= {(sao.negd[0] ? ldif : lsum), 27'b0};
    n10[1]    <= {(sao.negd[0] ? lsum : ldif), 27'b0};
    d10       <= (sar[1] == '0) ? 31'd1 : sar[1];
    s10.pos   <= sao.pos;
    s10.uy    <= sao.u[1];
    s10.uz    <= sao.u[2];
    s10.r     <= sar[0];
    s10.negy  <= sao.negd[1];
    s10.negz  <= sao.negd[2];
    s10.spec  <= (sar[0] == '0);
    s10.ident <= (sao.u[0] != '0) && !sao.negd[0];
    s10.k     <= sao.k;
    s10.last  <= sao.last;
  end

  logic               dbv;
  logic [1:0][28:0]   dbq;
  bsps_pkg::db_side_t dbo;

  bsps_div #(
    .LANES(2), .NW(59), .DW(31), .QW(29), .SW($bits(bsps_pkg::db_side_t))
  ) u_half_div (
    .clk(clk), .rst(rst), .in_valid(v10), .num(n10), .den(d10),
    .side_in(s10), .out_valid(dbv), .quo(dbq), .side_out(dbo)
  );

  // cos and sin of the half angle in Q2.14
  logic               hrv;
  logic [1:0][29:0]   hrx;
  logic [1:0][14:0]   hrr;
  logic [1:0][16:0]   hrm;
  bsps_pkg::db_side_t hro;

  assign hrx[0] = {1'b0, dbq[0]};
  assign hrx[1] = {1'b0, dbq[1]};

  bsps_sqrt #(
    .LANES(2), .XW(30), .SW($bits(bsps_pkg::db_side_t))
  ) u_half_sqrt (
    .clk(clk), .rst(rst), .in_valid(dbv), .x(hrx), .side_in(dbo),
    .out_valid(hrv), .root(hrr), .rem(hrm), .side_out(hro)
  );

  // ---------------------------------------------------------------------
  // Stage 11: round roots to nearest; 12: s times axis parts;
  // stage 13: numerators and divisor of the axis divide
  // ---------------------------------------------------------------------
  logic        v11, v12, v13;
  logic [14:0] qw11, sn11, qw12;
  bsps_pkg::db_side_t s11, s12;
  logic [44:0] py12, pz12;
  logic [1:0][45:0] n13;
  logic [31:0] d13;
  bsps_pkg::dd_side_t s13;

  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
      v12 <= 1'b0;
      v13 <= 1'b0;
    end else begin
      v11 <= hrv;
      v12 <= v11;
      v13 <= v12;
    end
    qw11 <= hrr[0] + ((hrm[0] > 17'(hrr[0])) ? 15'd1 : 15'd0);
    sn11 <= hrr[1] + ((hrm[1] > 17'(hrr[1])) ? 15'd1 : 15'd0);
    s11  <= hro;

    py12 <= {30'b0, sn11} * {15'b0, s11.uz};
    pz12 <= {30'b0, sn11} * {15'b0, s11.uy};
    qw12 <= qw11;
    s12  <= s11;

    n13[0]    <= {py12, 1'b0} + 46'(s12.r);
    n13[1]    <= {pz12, 1'b0} + 46'(s12.r);
    d13       <= s12.spec ? 32'd1 : {s12.r, 1'b0};
    s13.pos   <= s12.pos;
    s13.qw    <= qw12;
    s13.negy  <= s12.negy;
    s13.negz  <= s12.negz;
    s13.spec  <= s12.spec;
    s13.ident <= s12.ident;
    s13.k     <= s12.k;
    s13.last  <= s12.last;
  end

  logic               ddv;
  logic [1:0][14:0]   ddq;
  bsps_pkg::dd_side_t ddo;

  bsps_div #(
    .LANES(2), .NW(46), .DW(32), .QW(15), .SW($bits(bsps_pkg::dd_side_t))
  ) u_axis_div (
    .clk(clk), .rst(rst), .in_valid(v13), .num(n13), .den(d13),
    .side_in(s13), .out_valid(ddv), .quo(ddq), .side_out(ddo)
  );

  // ---------------------------------------------------------------------
  // Output register: signs and the axis-aligned cases
  // ---------------------------------------------------------------------
  logic signed [15:0] my, mz;

  assign my = $signed({1'b0, ddq[0]});
  assign mz = $signed({1'b0, ddq[1]});

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else     valid <= ddv;
    pos_x        <= ddo.pos[0];
    pos_y        <= ddo.pos[1];
    pos_z        <= ddo.pos[2];
    sample_index <= ddo.k;
    last_sample  <= ddo.last;
    if (ddo.spec) begin
      quat_w <= ddo.ident ? bsps_pkg::Q14_ONE : 16'sd0;
      quat_y <= 16'sd0;
      quat_z <= ddo.ident ? 16'sd0 : bsps_pkg::Q14_ONE;
    end else begin
      quat_w <= $signed({1'b0, ddo.qw});
      quat_y <= ddo.negz ? my : -my;
      quat_z <= ddo.negy ? -mz : mz;
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    valid && last_sample |-> sample_index == LASTK)
    else $error("last_sample on wrong index");

  a_consecutive: assert property (@(posedge clk) disable iff (rst)
    valid && !last_sample |=> valid && sample_index == $past(sample_index) + KW'(1))
    else $error("pose stream broken inside a segment");

  a_take: assert property (@(posedge clk) disable iff (rst)
    take |=> active && k == '0)
    else $error("segment accept did not restart the sequencer");

  a_qw_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> !quat_w[15] && quat_w <= bsps_pkg::Q14_ONE)
    else $error("quat_w out of range");

endmodule

`default_nettype wire
